// ===== hdl/pwswt_pkg.sv =====
// Shared constants for the pulse-width single-wire frame transmitter.
package pwswt_pkg;

    // The frame is made of a header, a payload and a footer.
    localparam int HEADER_BITS  = 12;
    localparam int PAYLOAD_BITS = 14;
    localparam int FOOTER_BITS  = 12;
    localparam int FRAME_BITS   = HEADER_BITS + PAYLOAD_BITS + FOOTER_BITS;
    localparam int POS_BITS     = 6;
    localparam int TICK_BITS    = 16;

    localparam logic [HEADER_BITS-1:0] HEADER_WORD = 12'h801;
    localparam logic [FOOTER_BITS-1:0] FOOTER_WORD = 12'h7FE;
    localparam logic [POS_BITS-1:0]    LAST_POS    = POS_BITS'(FRAME_BITS);

    // Command codes of an input word.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Register indexes of the configuration port.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ONE_HIGH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_HIGH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPACE     = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE    = 2'd3;

    // Reset values of the timing registers.
    localparam logic [TICK_BITS-1:0] RST_ONE_HIGH  = 16'd150;
    localparam logic [TICK_BITS-1:0] RST_ZERO_HIGH = 16'd2;
    localparam logic [TICK_BITS-1:0] RST_SPACE     = 16'd40;
    localparam logic [TICK_BITS-1:0] RST_SETTLE    = 16'd2000;

    // Phase codes of the sequencer.
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HIGH   = 2'd1;
    localparam logic [1:0] PH_SPACE  = 2'd2;
    localparam logic [1:0] PH_SETTLE = 2'd3;

    // One result word.
    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic frame_done;
        logic rejected;
    } t_result;

endpackage

// ===== hdl/pulse_width_single_wire_transmitter.sv =====
// Pulse-width single-wire frame transmitter: sequencer and result register.
// The result word for an input word is registered and shown in the cycle after it is accepted.
// Throughput: one input word per cycle while the input is not stalled; the sequencer state updates in the accept cycle.
// The input is stalled only while a result word waits and the output side stalls.
// Synchronous active-low reset clears the sequencer and the result valid flag and
// loads the timing registers with their default values.
module pulse_width_single_wire_transmitter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input channel.
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_command,
    input  logic [pwswt_pkg::PAYLOAD_BITS-1:0]    i_payload,
    // Result channel.
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_pin_level,
    output logic                                  o_busy_res,
    output logic                                  o_frame_done,
    output logic                                  o_rejected,
    // Configuration write channel.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pwswt_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [pwswt_pkg::TICK_BITS-1:0]       i_cfg_data
);

    localparam int FB = pwswt_pkg::FRAME_BITS;
    localparam int TB = pwswt_pkg::TICK_BITS;
    localparam int PB = pwswt_pkg::POS_BITS;

    // Timing registers.
    logic [TB-1:0] r_one_high;
    logic [TB-1:0] r_zero_high;
    logic [TB-1:0] r_space;
    logic [TB-1:0] r_settle;

    // Sequencer state.
    logic [FB-1:0] r_frame_shift, n_frame_shift;
    logic [PB-1:0] r_bit_pos,     n_bit_pos;
    logic [TB-1:0] r_tick_cnt,    n_tick_cnt;
    logic [1:0]    r_phase,       n_phase;
    logic          r_line,        n_line;

    // Result register.
    logic                 r_out_valid;
    pwswt_pkg::t_result   r_result, n_result;

    logic          in_accept;
    logic [TB-1:0] tick_inc;
    logic [TB-1:0] high_len;
    logic [PB-1:0] pos_inc;
    logic          done;
    logic          rejected;

    // An input word is taken unless a result word is held by the output side.
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_high  <= pwswt_pkg::RST_ONE_HIGH;
            r_zero_high <= pwswt_pkg::RST_ZERO_HIGH;
            r_space     <= pwswt_pkg::RST_SPACE;
            r_settle    <= pwswt_pkg::RST_SETTLE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pwswt_pkg::CFG_ONE_HIGH:  r_one_high  <= i_cfg_data;
                pwswt_pkg::CFG_ZERO_HIGH: r_zero_high <= i_cfg_data;
                pwswt_pkg::CFG_SPACE:     r_space     <= i_cfg_data;
                pwswt_pkg::CFG_SETTLE:    r_settle    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The tick counter wraps at its width; the next frame bit picks the pulse length.
    assign tick_inc = r_tick_cnt + TB'(1);
    assign pos_inc  = r_bit_pos + PB'(1);
    assign high_len = r_frame_shift[FB-1] ? r_one_high : r_zero_high;

    // Next state of the sequencer for the word at the input.
    always_comb begin
        n_frame_shift = r_frame_shift;
        n_bit_pos     = r_bit_pos;
        n_tick_cnt    = r_tick_cnt;
        n_phase       = r_phase;
        n_line        = r_line;
        done          = 1'b0;
        rejected      = 1'b0;
        if (i_command == pwswt_pkg::CMD_START) begin
            if (r_phase != pwswt_pkg::PH_IDLE) begin
                rejected = 1'b1;
            end else begin
                n_frame_shift = {pwswt_pkg::HEADER_WORD, i_payload, pwswt_pkg::FOOTER_WORD};
                n_bit_pos     = '0;
                n_tick_cnt    = '0;
                n_phase       = pwswt_pkg::PH_HIGH;
                n_line        = 1'b1;
            end
        end else begin
            case (r_phase)
                pwswt_pkg::PH_HIGH: begin
                    n_tick_cnt = tick_inc;
                    if (tick_inc >= high_len) begin
                        n_phase    = pwswt_pkg::PH_SPACE;
                        n_line     = 1'b0;
                        n_tick_cnt = '0;
                    end
                end
                pwswt_pkg::PH_SPACE: begin
                    n_tick_cnt = tick_inc;
                    if (tick_inc >= r_space) begin
                        n_tick_cnt    = '0;
                        n_frame_shift = {r_frame_shift[FB-2:0], 1'b0};
                        n_bit_pos     = pos_inc;
                        if (pos_inc >= pwswt_pkg::LAST_POS) begin
                            // A zero settle length ends the frame right here.
                            if (r_settle == '0) begin
                                n_phase = pwswt_pkg::PH_IDLE;
                                done    = 1'b1;
                            end else begin
                                n_phase = pwswt_pkg::PH_SETTLE;
                            end
                        end else begin
                            n_phase = pwswt_pkg::PH_HIGH;
                            n_line  = 1'b1;
                        end
                    end
                end
                pwswt_pkg::PH_SETTLE: begin
                    n_tick_cnt = tick_inc;
                    if (tick_inc >= r_settle) begin
                        n_tick_cnt = '0;
                        n_phase    = pwswt_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        n_result.pin_level  = n_line;
        n_result.busy_res   = (n_phase != pwswt_pkg::PH_IDLE);
        n_result.frame_done = done;
        n_result.rejected   = rejected;
    end

    // Sequencer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_shift <= '0;
            r_bit_pos     <= '0;
            r_tick_cnt    <= '0;
            r_phase       <= pwswt_pkg::PH_IDLE;
            r_line        <= 1'b0;
        end else if (in_accept) begin
            r_frame_shift <= n_frame_shift;
            r_bit_pos     <= n_bit_pos;
            r_tick_cnt    <= n_tick_cnt;
            r_phase       <= n_phase;
            r_line        <= n_line;
        end
    end

    // Result register: loaded on accept, emptied when the output side takes the word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pin_level  = r_result.pin_level;
    assign o_busy_res   = r_result.busy_res;
    assign o_frame_done = r_result.frame_done;
    assign o_rejected   = r_result.rejected;

endmodule

// ===== hdl/pwswt_checker.sv =====
// Port-level checker for the transmitter and its bind to the top level.
module pwswt_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic                                o_pin_level,
    input logic                                o_busy_res,
    input logic                                o_frame_done,
    input logic                                o_rejected
);

    // A result word held by the output side stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(o_out_valid && i_out_stall)) |->
        (o_out_valid && $stable(o_pin_level) && $stable(o_busy_res)
         && $stable(o_frame_done) && $stable(o_rejected)))
        else $error("result word changed while stalled");

    // Every accepted input word yields a result word in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("no result word after an accepted input word");

    // The end of a frame leaves the block idle with the pin low.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> (!o_busy_res && !o_pin_level && !o_rejected))
        else $error("frame done while still busy");

    // A high pin or a rejected start only happens during a frame.
    a_busy_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_pin_level || o_rejected)) |-> o_busy_res)
        else $error("pin high or start rejected while idle");

endmodule

bind pulse_width_single_wire_transmitter pwswt_checker u_pwswt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_pin_level  (o_pin_level),
    .o_busy_res   (o_busy_res),
    .o_frame_done (o_frame_done),
    .o_rejected   (o_rejected)
);

// ===== sim/pulse_width_single_wire_transmitter_tb.sv =====
// Testbench for the pulse-width single-wire frame transmitter.
`timescale 1ns / 1ps

module pulse_width_single_wire_transmitter_tb;
    import pwswt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PLAN_ROWS   = 23;
    localparam int WORK_WORDS  = 520;

    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    // One row of the directed plan: either an input word or a register write.
    typedef struct {
        t_row_kind                kind;
        logic                     cmd;
        logic [PAYLOAD_BITS-1:0]  pl;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [TICK_BITS-1:0]     data;
        int                       reps;
        bit                       typed;
        t_result                  want;
    } t_plan_row;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     i_command   = CMD_TICK;
    logic [PAYLOAD_BITS-1:0]  i_payload   = '0;
    logic                     i_out_stall = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = CFG_ONE_HIGH;
    logic [TICK_BITS-1:0]     i_cfg_data  = '0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic                     o_pin_level;
    logic                     o_busy_res;
    logic                     o_frame_done;
    logic                     o_rejected;
    logic                     o_cfg_ready;

    pulse_width_single_wire_transmitter u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_payload    (i_payload),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pin_level  (o_pin_level),
        .o_busy_res   (o_busy_res),
        .o_frame_done (o_frame_done),
        .o_rejected   (o_rejected),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the timing registers and the sequencer.
    logic [TICK_BITS-1:0]   len_one    = RST_ONE_HIGH;
    logic [TICK_BITS-1:0]   len_zero   = RST_ZERO_HIGH;
    logic [TICK_BITS-1:0]   len_space  = RST_SPACE;
    logic [TICK_BITS-1:0]   len_settle = RST_SETTLE;
    logic [FRAME_BITS-1:0]  frame_bits = '0;
    logic [POS_BITS-1:0]    bits_sent  = '0;
    logic [TICK_BITS-1:0]   ticks      = '0;
    logic [1:0]             ph_now     = PH_IDLE;
    logic                   level      = 1'b0;

    t_result line_results_due[$];
    int      mismatch_count = 0;
    int      cycles         = 0;
    int      burst_left     = 0;
    int      stall_hold     = 0;
    t_result seen;
    t_result due;

    // Advances the shadow sequencer by one word and returns the line state it shows.
    function automatic t_result predict_line(input logic cmd,
                                             input logic [PAYLOAD_BITS-1:0] pl);
        t_result              res;
        logic [TICK_BITS-1:0] lim;
        res = '0;
        if (cmd == CMD_START) begin
            if (ph_now != PH_IDLE) begin
                res.rejected = 1'b1;
            end else begin
                frame_bits = {HEADER_WORD, pl, FOOTER_WORD};
                bits_sent  = '0;
                ticks      = '0;
                ph_now     = PH_HIGH;
                level      = 1'b1;
            end
        end else begin
            case (ph_now)
                PH_HIGH: begin
                    lim   = frame_bits[FRAME_BITS-1] ? len_one : len_zero;
                    ticks = ticks + 1'b1;
                    if (ticks >= lim) begin
                        ph_now = PH_SPACE;
                        level  = 1'b0;
                        ticks  = '0;
                    end
                end
                PH_SPACE: begin
                    ticks = ticks + 1'b1;
                    if (ticks >= len_space) begin
                        ticks      = '0;
                        frame_bits = frame_bits << 1;
                        bits_sent  = bits_sent + 1'b1;
                        if (bits_sent >= LAST_POS) begin
                            if (len_settle == '0) begin
                                ph_now         = PH_IDLE;
                                res.frame_done = 1'b1;
                            end else begin
                                ph_now = PH_SETTLE;
                            end
                        end else begin
                            ph_now = PH_HIGH;
                            level  = 1'b1;
                        end
                    end
                end
                PH_SETTLE: begin
                    ticks = ticks + 1'b1;
                    if (ticks >= len_settle) begin
                        ticks          = '0;
                        ph_now         = PH_IDLE;
                        res.frame_done = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        res.pin_level = level;
        res.busy_res  = (ph_now != PH_IDLE);
        return res;
    endfunction

    // Mostly back-to-back words, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst_left = $urandom_range(10, 60);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Short timing values keep frames brief; zero shows up now and then.
    function automatic logic [TICK_BITS-1:0] pick_len(input int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 92) return TICK_BITS'($urandom_range(1, hi));
        return TICK_BITS'($urandom_range(hi + 1, 24));
    endfunction

    task automatic send_word(input logic cmd, input logic [PAYLOAD_BITS-1:0] pl,
                             input bit typed, input t_result want);
        int      gap;
        t_result res;
        i_cfg_valid <= 1'b0;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_payload  <= pl;
        do @(posedge i_clk); while (o_in_stall);
        res = predict_line(cmd, pl);
        line_results_due.push_back(typed ? want : res);
    endtask

    // Registers change only once every outstanding result word has come back.
    task automatic write_timing_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [TICK_BITS-1:0] val);
        i_in_valid <= 1'b0;
        while (line_results_due.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ONE_HIGH:  len_one    = val;
            CFG_ZERO_HIGH: len_zero   = val;
            CFG_SPACE:     len_space  = val;
            CFG_SETTLE:    len_settle = val;
            default: ;
        endcase
    endtask

    task automatic flag_error(input string what, input t_result want, input t_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display({"%0t %s: expected pin=%0b busy=%0b done=%0b rej=%0b,",
                      " got pin=%0b busy=%0b done=%0b rej=%0b"},
                     $realtime, what, want.pin_level, want.busy_res, want.frame_done,
                     want.rejected, got.pin_level, got.busy_res, got.frame_done, got.rejected);
        end
    endtask

    // Result side: compare each accepted word, then choose the next stall pattern.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = '{o_pin_level, o_busy_res, o_frame_done, o_rejected};
            if (line_results_due.size() == 0) begin
                flag_error("result word with none due", '0, seen);
            end else begin
                due = line_results_due.pop_front();
                if (seen.pin_level !== due.pin_level || seen.busy_res !== due.busy_res ||
                    seen.frame_done !== due.frame_done || seen.rejected !== due.rejected) begin
                    flag_error("result word mismatch", due, seen);
                end
            end
        end
        if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            case ($urandom_range(0, 19) / 5)
                0, 1: begin
                    i_out_stall <= 1'b0;
                    stall_hold = $urandom_range(0, 30);
                end
                2: begin
                    i_out_stall <= 1'b1;
                    stall_hold = $urandom_range(0, 2);
                end
                default: begin
                    i_out_stall <= ($urandom_range(0, 9) == 0);
                    stall_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : 0;
                end
            endcase
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_plan_row               plan [PLAN_ROWS];
        int                      worked;
        int                      span;
        bit                      first;
        logic                    cmd;
        logic [PAYLOAD_BITS-1:0] pl;
        plan = '{
            // Idle ticks do nothing; a start goes high at once; a second start is refused.
            '{ROW_WORD, CMD_TICK,  14'h0000, CFG_ONE_HIGH,  16'd0,     1,  1'b1, 4'b0000},
            '{ROW_WORD, CMD_TICK,  14'h3FFF, CFG_ONE_HIGH,  16'd0,     1,  1'b1, 4'b0000},
            '{ROW_WORD, CMD_START, 14'h3FFF, CFG_ONE_HIGH,  16'd0,     1,  1'b1, 4'b1100},
            '{ROW_WORD, CMD_START, 14'h0000, CFG_ONE_HIGH,  16'd0,     1,  1'b1, 4'b1101},
            '{ROW_WORD, CMD_TICK,  14'h0000, CFG_ONE_HIGH,  16'd0,     3,  1'b0, 4'b0000},
            // Zero lengths written mid-frame; zero settle ends the frame on the last space.
            '{ROW_REG,  CMD_TICK,  14'h0000, CFG_ONE_HIGH,  16'd0,     1,  1'b0, 4'b0000},
            '{ROW_REG,  CMD_TICK,  14'h0000, CFG_ZERO_HIGH, 16'd0,     1,  1'b0, 4'b0000},
            '{ROW_REG,  CMD_TICK,  14'h0000, CFG_SPACE,     16'd0,     1,  1'b0, 4'b0000},
            '{ROW_REG,  CMD_TICK,  14'h0000, CFG_SETTLE,    16'd0,     1,  1'b0, 4'b0000},
            '{ROW_WORD, CMD_TICK,  14'h3FFF, CFG_ONE_HIGH,  16'd0,     76, 1'b0, 4'b0000},
            '{ROW_WORD, CMD_TICK,  14'h0000, CFG_ONE_HIGH,  16'd0,     1,  1'b0, 4'b0000},
            // Largest lengths, then cut short mid-pulse by small ones.
            '{ROW_REG,  CMD_TICK,  14'h0000, CFG_ONE_HIGH,  16'hFFFF,  1,  1'b0, 4'b0000},
            '{ROW_REG,  CMD_TICK,  14'h0000, CFG_ZERO_HIGH, 16'hFFFF,  1,  1'b0, 4'b0000},
            '{ROW_REG,  CMD_TICK,  14'h0000, CFG_SPACE,     16'hFFFF,  1,  1'b0, 4'b0000},
            '{ROW_REG,  CMD_TICK,  14'h0000, CFG_SETTLE,    16'hFFFF,  1,  1'b0, 4'b0000},
            '{ROW_WORD, CMD_START, 14'h0000, CFG_ONE_HIGH,  16'd0,     1,  1'b1, 4'b1100},
            '{ROW_WORD, CMD_TICK,  14'h1555, CFG_ONE_HIGH,  16'd0,     20, 1'b0, 4'b0000},
            '{ROW_REG,  CMD_TICK,  14'h0000, CFG_ONE_HIGH,  16'd1,     1,  1'b0, 4'b0000},
            '{ROW_REG,  CMD_TICK,  14'h0000, CFG_ZERO_HIGH, 16'd2,     1,  1'b0, 4'b0000},
            '{ROW_REG,  CMD_TICK,  14'h0000, CFG_SPACE,     16'd1,     1,  1'b0, 4'b0000},
            '{ROW_REG,  CMD_TICK,  14'h0000, CFG_SETTLE,    16'd3,     1,  1'b0, 4'b0000},
            '{ROW_WORD, CMD_START, 14'h2AAA, CFG_ONE_HIGH,  16'd0,     1,  1'b1, 4'b1101},
            '{ROW_WORD, CMD_TICK,  14'h2AAA, CFG_ONE_HIGH,  16'd0,     110, 1'b0, 4'b0000}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed plan.
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                write_timing_reg(plan[i].idx, plan[i].data);
            end else begin
                repeat (plan[i].reps)
                    send_word(plan[i].cmd, plan[i].pl, plan[i].typed, plan[i].want);
            end
        end

        // Random part: mostly well-formed frames with random payloads and timing,
        // some refused starts, idle ticks and mid-frame register changes.
        worked = 0;
        first  = 1'b1;
        while (worked < WORK_WORDS) begin
            if (first || $urandom_range(0, 99) < 70) write_timing_reg(CFG_ONE_HIGH, pick_len(5));
            if (first || $urandom_range(0, 99) < 70) write_timing_reg(CFG_ZERO_HIGH, pick_len(5));
            if (first || $urandom_range(0, 99) < 70) write_timing_reg(CFG_SPACE, pick_len(4));
            if (first || $urandom_range(0, 99) < 70) write_timing_reg(CFG_SETTLE, pick_len(10));
            first = 1'b0;
            span  = $urandom_range(40, 160);
            repeat (span) begin
                if ($urandom_range(0, 99) < 2) begin
                    write_timing_reg(CFG_IDX_BITS'($urandom_range(0, 3)), pick_len(8));
                end
                if (ph_now == PH_IDLE) begin
                    cmd = ($urandom_range(0, 99) < 85) ? CMD_START : CMD_TICK;
                end else begin
                    cmd = ($urandom_range(0, 99) < 4) ? CMD_START : CMD_TICK;
                end
                if ($urandom_range(0, 9) == 0) begin
                    pl = $urandom_range(0, 1) ? '1 : '0;
                end else begin
                    pl = PAYLOAD_BITS'($urandom_range(0, 16383));
                end
                if (!(cmd == CMD_TICK && ph_now == PH_IDLE)) worked++;
                send_word(cmd, pl, 1'b0, '0);
            end
        end

        // Drain and report.
        i_in_valid <= 1'b0;
        while (line_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== pulse_width_single_wire_transmitter.f =====
hdl/pwswt_pkg.sv
hdl/pulse_width_single_wire_transmitter.sv
hdl/pwswt_checker.sv
sim/pulse_width_single_wire_transmitter_tb.sv
